// ===== src/pss_pkg.sv =====
package pss_pkg;

    localparam int SENDERS   = 256;
    localparam int ID_W      = 8;
    localparam int IDX_W     = (SENDERS > 1) ? $clog2(SENDERS) : 1;
    localparam int DATA_W    = 32;
    localparam int RETRY_W   = 8;
    localparam int PROD_W    = DATA_W + RETRY_W;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    localparam logic [ID_W:0]    SENDERS_LIM        = (ID_W + 1)'(SENDERS);
    localparam logic [0:0]       REG_PACKET_RETRIES = 1'b0;
    localparam logic [RETRY_W-1:0] RETRIES_RESET    = RETRY_W'(3);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_OUT
    } pss_state_t;

    typedef struct packed {
        logic capture;
        logic calc;
        logic load;
    } pss_cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] raw;
        logic [DATA_W-1:0] logical;
        logic [DATA_W-1:0] last;
        logic [DATA_W-1:0] highest;
    } pss_entry_t;

endpackage

// ===== src/pss_ctrl.sv =====
module pss_ctrl
    import pss_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output pss_cmd_t cmd
);

    pss_state_t state_reg;
    pss_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.calc    = 1'b0;
        cmd.load    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.load = 1'b1;
                    in_ready = 1'b1;
                    if (in_valid)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_CALC;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

// ===== src/pss_dp.sv =====
module pss_dp
    import pss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  pss_cmd_t           cmd,
    input  logic [RETRY_W-1:0] retry_count,
    input  logic               mode,
    input  logic [ID_W-1:0]    sender_id,
    input  logic [DATA_W-1:0]  seq,
    input  logic               length_ok,
    output logic               ignored,
    output logic               duplicate,
    output logic               seen,
    output logic [DATA_W-1:0]  logical_rx,
    output logic [DATA_W-1:0]  logical_exp,
    output logic [DATA_W-1:0]  logical_lost,
    output logic [DATA_W-1:0]  raw_rx,
    output logic [DATA_W-1:0]  exp_raw,
    output logic [DATA_W-1:0]  raw_lost
);

    // Entries whose seen bit is clear read as all zero, so reset needs no sweep.
    pss_entry_t         entry_mem_reg [SENDERS];
    logic [SENDERS-1:0] seen_bits_reg;

    logic               mode_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               id_ok_reg;
    logic [DATA_W-1:0]  seq_reg;
    logic               len_ok_reg;
    pss_entry_t         rd_data_reg;
    logic               rd_seen_reg;

    logic               st_ign_reg;
    logic               st_dup_reg;
    logic               st_seen_reg;
    logic [DATA_W-1:0]  st_recv_l_reg;
    logic [DATA_W-1:0]  st_exp_l_reg;
    logic [DATA_W-1:0]  st_lost_l_reg;
    logic [DATA_W-1:0]  st_recv_r_reg;
    logic [DATA_W-1:0]  st_exp_r_reg;

    logic               ign_reg;
    logic               dup_reg;
    logic               seen_out_reg;
    logic [DATA_W-1:0]  recv_l_reg;
    logic [DATA_W-1:0]  exp_l_reg;
    logic [DATA_W-1:0]  lost_l_reg;
    logic [DATA_W-1:0]  recv_r_reg;
    logic [DATA_W-1:0]  exp_r_reg;
    logic [DATA_W-1:0]  lost_r_reg;

    logic [IDX_W-1:0]   rd_idx;
    pss_entry_t         cur;
    pss_entry_t         upd;
    logic               pkt_ok;
    logic               is_dup;
    logic               mem_we;
    logic [DATA_W-1:0]  exp_l;
    logic [PROD_W-1:0]  prod;
    logic               q_ok;

    assign rd_idx = sender_id[IDX_W-1:0];
    assign cur    = rd_seen_reg ? rd_data_reg : '0;
    assign pkt_ok = !mode_reg && len_ok_reg && id_ok_reg;
    assign is_dup = rd_seen_reg && (seq_reg == cur.last);
    assign q_ok   = mode_reg && id_ok_reg;
    assign mem_we = cmd.calc && pkt_ok;
    assign exp_l  = cur.highest + DATA_W'(1);
    assign prod   = PROD_W'(exp_l) * PROD_W'(retry_count);

    always_comb
    begin
        upd.raw     = cur.raw + DATA_W'(1);
        upd.highest = (seq_reg > cur.highest) ? seq_reg : cur.highest;
        upd.last    = is_dup ? cur.last : seq_reg;
        upd.logical = is_dup ? cur.logical : cur.logical + DATA_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem_reg[idx_reg] <= upd;
        end
        if (cmd.capture)
        begin
            rd_data_reg <= entry_mem_reg[rd_idx];
            rd_seen_reg <= seen_bits_reg[rd_idx];
            mode_reg    <= mode;
            idx_reg     <= rd_idx;
            id_ok_reg   <= ({1'b0, sender_id} < SENDERS_LIM);
            seq_reg     <= seq;
            len_ok_reg  <= length_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_bits_reg <= '0;
        end
        else if (cmd.calc)
        begin
            if (pkt_ok)
            begin
                seen_bits_reg[idx_reg] <= 1'b1;
            end
            else if (q_ok)
            begin
                seen_bits_reg[idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            st_ign_reg    <= !mode_reg && !pkt_ok;
            st_dup_reg    <= pkt_ok && is_dup;
            st_seen_reg   <= q_ok && rd_seen_reg;
            st_recv_l_reg <= q_ok ? cur.logical : '0;
            st_exp_l_reg  <= q_ok ? exp_l : '0;
            st_lost_l_reg <= q_ok ? exp_l - cur.logical : '0;
            st_recv_r_reg <= q_ok ? cur.raw : '0;
            st_exp_r_reg  <= q_ok ? prod[DATA_W-1:0] : '0;
        end
        if (cmd.load)
        begin
            ign_reg      <= st_ign_reg;
            dup_reg      <= st_dup_reg;
            seen_out_reg <= st_seen_reg;
            recv_l_reg   <= st_recv_l_reg;
            exp_l_reg    <= st_exp_l_reg;
            lost_l_reg   <= st_lost_l_reg;
            recv_r_reg   <= st_recv_r_reg;
            exp_r_reg    <= st_exp_r_reg;
            lost_r_reg   <= st_exp_r_reg - st_recv_r_reg;
        end
    end

    assign ignored      = ign_reg;
    assign duplicate    = dup_reg;
    assign seen         = seen_out_reg;
    assign logical_rx   = recv_l_reg;
    assign logical_exp  = exp_l_reg;
    assign logical_lost = lost_l_reg;
    assign raw_rx       = recv_r_reg;
    assign exp_raw      = exp_r_reg;
    assign raw_lost     = lost_r_reg;

endmodule

// ===== src/per_source_packet_sequence_stats.sv =====
// A beat's table entry is read into the capture registers, updated and written back in the
// calc state for a packet, where a query's expected raw count is multiplied out instead,
// and the result is then loaded into the output registers; the next beat is taken as the
// result is loaded, and a result that is not taken holds the input off until it is.
// Reset clears the control state and every sender's seen bit at once, so the
// whole table reads as zero straight after reset; the retry count resets to 3.
module per_source_packet_sequence_stats
    import pss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              mode,
    input  logic [ID_W-1:0]   sender_id,
    input  logic [DATA_W-1:0] seq,
    input  logic              length_ok,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              ignored,
    output logic              duplicate,
    output logic              seen,
    output logic [DATA_W-1:0] logical_rx,
    output logic [DATA_W-1:0] logical_exp,
    output logic [DATA_W-1:0] logical_lost,
    output logic [DATA_W-1:0] raw_rx,
    output logic [DATA_W-1:0] exp_raw,
    output logic [DATA_W-1:0] raw_lost
);

    logic [RETRY_W-1:0] retries_reg;
    logic [RETRY_W-1:0] retries_next;
    logic               cfg_wr;
    pss_cmd_t           cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_PACKET_RETRIES);

    always_comb
    begin
        retries_next = cfg_wr ? pwdata[RETRY_W-1:0] : retries_reg;
        prdata       = (paddr[2] == REG_PACKET_RETRIES) ?
                       APB_DW'(retries_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retries_reg <= RETRIES_RESET;
        end
        else
        begin
            retries_reg <= retries_next;
        end
    end

    pss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    pss_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .retry_count  (retries_reg),
        .mode         (mode),
        .sender_id    (sender_id),
        .seq          (seq),
        .length_ok    (length_ok),
        .ignored      (ignored),
        .duplicate    (duplicate),
        .seen         (seen),
        .logical_rx   (logical_rx),
        .logical_exp  (logical_exp),
        .logical_lost (logical_lost),
        .raw_rx       (raw_rx),
        .exp_raw      (exp_raw),
        .raw_lost     (raw_lost)
    );

endmodule

// ===== tb/pss_tb_pkg.sv =====
`timescale 1ns / 1ps

package pss_tb_pkg;

    import pss_pkg::*;

    typedef enum logic {
        MODE_PACKET = 1'b0,
        MODE_QUERY  = 1'b1
    } beat_mode_t;

    localparam logic [APB_AW-1:0] RETRIES_ADDR = APB_AW'(4 * REG_PACKET_RETRIES);

endpackage

// ===== tb/pss_stats_checker.sv =====
`timescale 1ns / 1ps

module pss_stats_checker
    import pss_pkg::*;
    import pss_tb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              mode,
    input  logic [ID_W-1:0]   sender_id,
    input  logic [DATA_W-1:0] seq,
    input  logic              length_ok,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic              ignored,
    input  logic              duplicate,
    input  logic              seen,
    input  logic [DATA_W-1:0] logical_rx,
    input  logic [DATA_W-1:0] logical_exp,
    input  logic [DATA_W-1:0] logical_lost,
    input  logic [DATA_W-1:0] raw_rx,
    input  logic [DATA_W-1:0] exp_raw,
    input  logic [DATA_W-1:0] raw_lost,
    output int                mismatches,
    output int                waiting
);

    typedef struct packed {
        logic              ignored;
        logic              duplicate;
        logic              seen;
        logic [DATA_W-1:0] logical_rx;
        logic [DATA_W-1:0] logical_exp;
        logic [DATA_W-1:0] logical_lost;
        logic [DATA_W-1:0] raw_rx;
        logic [DATA_W-1:0] exp_raw;
        logic [DATA_W-1:0] raw_lost;
    } stats_beat_t;

    logic [DATA_W-1:0]  raw_tally     [SENDERS];
    logic [DATA_W-1:0]  logical_tally [SENDERS];
    logic [DATA_W-1:0]  last_seq      [SENDERS];
    logic [DATA_W-1:0]  top_seq       [SENDERS];
    logic               seen_bit      [SENDERS];
    logic [RETRY_W-1:0] retries;
    stats_beat_t        expected_stats[$];

    function automatic stats_beat_t predict_stats(beat_mode_t m, logic [ID_W-1:0] id,
                                                  logic [DATA_W-1:0] s, logic lok);
        stats_beat_t       r;
        logic [DATA_W-1:0] exp_l;
        logic [DATA_W-1:0] exp_r;
        int                i;
        r = '0;
        i = int'(id);
        if (m == MODE_PACKET)
        begin
            if (!lok || i >= SENDERS)
            begin
                r.ignored = 1'b1;
                return r;
            end
            raw_tally[i] = raw_tally[i] + 1;
            if (s > top_seq[i])
                top_seq[i] = s;
            if (seen_bit[i] && s == last_seq[i])
            begin
                r.duplicate = 1'b1;
                return r;
            end
            last_seq[i]      = s;
            seen_bit[i]      = 1'b1;
            logical_tally[i] = logical_tally[i] + 1;
            return r;
        end
        if (i >= SENDERS)
            return r;
        exp_l          = top_seq[i] + 1;
        exp_r          = exp_l * DATA_W'(retries);
        r.seen         = seen_bit[i];
        r.logical_rx   = logical_tally[i];
        r.logical_exp  = exp_l;
        r.logical_lost = exp_l - logical_tally[i];
        r.raw_rx       = raw_tally[i];
        r.exp_raw      = exp_r;
        r.raw_lost     = exp_r - raw_tally[i];
        if (seen_bit[i])
        begin
            raw_tally[i]     = '0;
            logical_tally[i] = '0;
            last_seq[i]      = '0;
            top_seq[i]       = '0;
            seen_bit[i]      = 1'b0;
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        stats_beat_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SENDERS; i++)
            begin
                raw_tally[i]     = '0;
                logical_tally[i] = '0;
                last_seq[i]      = '0;
                top_seq[i]       = '0;
                seen_bit[i]      = 1'b0;
            end
            retries = RETRIES_RESET;
            expected_stats.delete();
            mismatches = 0;
            waiting    = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == RETRIES_ADDR)
                retries = pwdata[RETRY_W-1:0];
            if (out_valid && out_ready)
            begin
                if (expected_stats.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result beat with none expected, actual ignored %0b %s %0b",
                             $time, ignored, "duplicate", duplicate);
                end
                else
                begin
                    want = expected_stats.pop_front();
                    check_field("ignored", DATA_W'(want.ignored), DATA_W'(ignored));
                    check_field("duplicate", DATA_W'(want.duplicate), DATA_W'(duplicate));
                    check_field("seen", DATA_W'(want.seen), DATA_W'(seen));
                    check_field("logical_rx", want.logical_rx, logical_rx);
                    check_field("logical_exp", want.logical_exp, logical_exp);
                    check_field("logical_lost", want.logical_lost, logical_lost);
                    check_field("raw_rx", want.raw_rx, raw_rx);
                    check_field("exp_raw", want.exp_raw, exp_raw);
                    check_field("raw_lost", want.raw_lost, raw_lost);
                end
            end
            if (in_valid && in_ready)
                expected_stats.push_back(predict_stats(beat_mode_t'(mode), sender_id, seq,
                                                       length_ok));
            waiting = expected_stats.size();
        end
    end

endmodule

// ===== tb/tb_per_source_packet_sequence_stats.sv =====
`timescale 1ns / 1ps

module tb_per_source_packet_sequence_stats;

    import pss_pkg::*;
    import pss_tb_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              in_valid;
    logic              in_ready;
    logic              mode;
    logic [ID_W-1:0]   sender_id;
    logic [DATA_W-1:0] seq;
    logic              length_ok;
    logic              out_valid;
    logic              out_ready;
    logic              ignored;
    logic              duplicate;
    logic              seen;
    logic [DATA_W-1:0] logical_rx;
    logic [DATA_W-1:0] logical_exp;
    logic [DATA_W-1:0] logical_lost;
    logic [DATA_W-1:0] raw_rx;
    logic [DATA_W-1:0] exp_raw;
    logic [DATA_W-1:0] raw_lost;

    int                mismatches;
    int                waiting;
    logic              calm;
    logic [DATA_W-1:0] sent_seq [SENDERS];
    logic [ID_W-1:0]   id_pool  [6];

    per_source_packet_sequence_stats dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .sender_id    (sender_id),
        .seq          (seq),
        .length_ok    (length_ok),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .ignored      (ignored),
        .duplicate    (duplicate),
        .seen         (seen),
        .logical_rx   (logical_rx),
        .logical_exp  (logical_exp),
        .logical_lost (logical_lost),
        .raw_rx       (raw_rx),
        .exp_raw      (exp_raw),
        .raw_lost     (raw_lost)
    );

    pss_stats_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .sender_id    (sender_id),
        .seq          (seq),
        .length_ok    (length_ok),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .ignored      (ignored),
        .duplicate    (duplicate),
        .seen         (seen),
        .logical_rx   (logical_rx),
        .logical_exp  (logical_exp),
        .logical_lost (logical_lost),
        .raw_rx       (raw_rx),
        .exp_raw      (exp_raw),
        .raw_lost     (raw_lost),
        .mismatches   (mismatches),
        .waiting      (waiting)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(negedge clk)
    begin
        out_ready <= calm || ($urandom_range(0, 99) >= 11);
    end

    task automatic send_beat(beat_mode_t m, logic [ID_W-1:0] id, logic [DATA_W-1:0] s,
                             logic lok);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 11)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        sender_id <= id;
        seq       <= s;
        length_ok <= lok;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic write_reg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_beat();
        logic [ID_W-1:0]   id;
        logic [DATA_W-1:0] s;
        int                pick;
        if ($urandom_range(0, 99) < 70)
            id = id_pool[$urandom_range(0, 5)];
        else
            id = ID_W'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 15)
        begin
            send_beat(MODE_QUERY, id, $urandom, 1'($urandom_range(0, 1)));
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 58)
            s = sent_seq[id] + 1;
        else if (pick < 73)
            s = sent_seq[id];
        else if (pick < 83)
            s = sent_seq[id] + $urandom_range(2, 50);
        else if (pick < 93)
            s = $urandom;
        else if (pick < 96)
            s = '0;
        else
            s = 32'hFFFF_FFFF - $urandom_range(0, 3);
        sent_seq[id] = s;
        send_beat(MODE_PACKET, id, s, $urandom_range(0, 99) >= 10);
    endtask

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        logic [RETRY_W-1:0] r;
        rst_n     = 1'b0;
        calm      = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        mode      = MODE_PACKET;
        sender_id = '0;
        seq       = '0;
        length_ok = 1'b0;
        for (int i = 0; i < SENDERS; i++)
            sent_seq[i] = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // A first packet with sequence zero must not count as a repeat of the
        // cleared last sequence; a maximal sequence wraps the expected count.
        send_beat(MODE_QUERY, 8'd0, 32'hFFFF_FFFF, 1'b1);
        send_beat(MODE_PACKET, 8'd0, 32'h0, 1'b1);
        send_beat(MODE_PACKET, 8'd0, 32'h0, 1'b1);
        send_beat(MODE_PACKET, 8'd0, 32'hFFFF_FFFF, 1'b1);
        send_beat(MODE_PACKET, 8'd0, 32'hFFFF_FFFF, 1'b1);
        send_beat(MODE_PACKET, 8'd0, 32'h1234_5678, 1'b0);
        send_beat(MODE_QUERY, 8'd0, 32'h0, 1'b0);
        send_beat(MODE_QUERY, 8'd0, 32'h0, 1'b1);
        send_beat(MODE_PACKET, 8'd255, 32'd5, 1'b1);
        send_beat(MODE_PACKET, 8'd255, 32'd5, 1'b1);
        send_beat(MODE_PACKET, 8'd255, 32'd3, 1'b1);
        send_beat(MODE_PACKET, 8'd255, 32'd9, 1'b1);
        send_beat(MODE_PACKET, 8'd255, 32'd5, 1'b1);
        send_beat(MODE_QUERY, 8'd255, 32'hAAAA_5555, 1'b1);
        send_beat(MODE_PACKET, 8'hAA, 32'h5555_AAAA, 1'b1);
        send_beat(MODE_PACKET, 8'h55, 32'hAAAA_5555, 1'b1);
        send_beat(MODE_QUERY, 8'hAA, 32'h0, 1'b1);
        send_beat(MODE_QUERY, 8'h55, 32'h0, 1'b1);
        send_beat(MODE_QUERY, 8'd17, 32'h0, 1'b1);

        for (int ph = 0; ph < 5; ph++)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            while (waiting != 0)
                @(negedge clk);
            case (ph)
                0:       r = 8'd255;
                1:       r = 8'd0;
                2:       r = 8'd1;
                default: r = RETRY_W'($urandom_range(1, 255));
            endcase
            write_reg(RETRIES_ADDR, APB_DW'(r));
            for (int k = 0; k < 6; k++)
                id_pool[k] = ID_W'($urandom_range(0, 255));
            if (ph == 0)
                id_pool[0] = 8'd0;
            if (ph == 1)
                id_pool[1] = 8'd255;
            calm = (ph == 2);
            repeat (190) random_beat();
        end
        @(negedge clk);
        in_valid <= 1'b0;
        calm = 1'b0;
        while (waiting != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && waiting == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
